// ----- rtl/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg: shared types, constants and lookup functions
// The end-of-string snapshot, character codes and the name and calendar
// tables used by the date parser.
// ----------------------------------------------------------------------------
package rdp_pkg;

    // Fixed-width part of the parse state captured at the end of a string.
    typedef struct packed {
        logic       base_ok;
        logic       day_minus;
        logic       day_top;
        logic [7:0] day_low;
        logic [3:0] month;
        logic       year_minus;
    } snap_t;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_NUL   = 8'd0;

    localparam int YEAR_CENTURY    = 1900;
    localparam int YEAR_PIVOT      = 50;
    localparam int YEAR_MILLENNIUM = 2000;
    localparam int NAME_LEN        = 3;

    // floor(y / 100) = (y * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit y
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

    localparam logic [23:0] DAY_SUN = "Sun";
    localparam logic [23:0] DAY_MON = "Mon";
    localparam logic [23:0] DAY_TUE = "Tue";
    localparam logic [23:0] DAY_WED = "Wed";
    localparam logic [23:0] DAY_THU = "Thu";
    localparam logic [23:0] DAY_FRI = "Fri";
    localparam logic [23:0] DAY_SAT = "Sat";

    localparam logic [23:0] MON_JAN = "Jan";
    localparam logic [23:0] MON_FEB = "Feb";
    localparam logic [23:0] MON_MAR = "Mar";
    localparam logic [23:0] MON_APR = "Apr";
    localparam logic [23:0] MON_MAY = "May";
    localparam logic [23:0] MON_JUN = "Jun";
    localparam logic [23:0] MON_JUL = "Jul";
    localparam logic [23:0] MON_AUG = "Aug";
    localparam logic [23:0] MON_SEP = "Sep";
    localparam logic [23:0] MON_OCT = "Oct";
    localparam logic [23:0] MON_NOV = "Nov";
    localparam logic [23:0] MON_DEC = "Dec";

    localparam logic [3:0] MONTH_FEB = 4'd2;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_day_name(logic [23:0] n);
        logic hit;
        case (n)
            DAY_SUN, DAY_MON, DAY_TUE, DAY_WED,
            DAY_THU, DAY_FRI, DAY_SAT: hit = 1'b1;
            default:                   hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [3:0] month_code(logic [23:0] n);
        logic [3:0] m;
        case (n)
            MON_JAN: m = 4'd1;
            MON_FEB: m = 4'd2;
            MON_MAR: m = 4'd3;
            MON_APR: m = 4'd4;
            MON_MAY: m = 4'd5;
            MON_JUN: m = 4'd6;
            MON_JUL: m = 4'd7;
            MON_AUG: m = 4'd8;
            MON_SEP: m = 4'd9;
            MON_OCT: m = 4'd10;
            MON_NOV: m = 4'd11;
            MON_DEC: m = 4'd12;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

    // Days in a common year; zero for a code that is no month.
    function automatic logic [4:0] month_len(logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/rdp_if.sv -----
// ----------------------------------------------------------------------------
// rdp_if: channel interfaces of the date parser
// Character input channel and parsed date output channel, valid/ready.
// ----------------------------------------------------------------------------
interface rdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rdp_out_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [15:0] year_number;

    modport source (output valid, output date_valid, output day_of_month,
                    output month_number, output year_number, input ready);
    modport sink   (input valid, input date_valid, input day_of_month,
                    input month_number, input year_number, output ready);
endinterface

// ----- rtl/rdp_scanner.sv -----
// ----------------------------------------------------------------------------
// rdp_scanner: character scanner of the date parser
// Registers each character beat, advances the parse state one byte per cycle
// unless an end beat waits for room, and snapshots the state at a string end.
// ----------------------------------------------------------------------------
module rdp_scanner
    import rdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rdp_in_if.sink                 char_in,
    output logic                   snap_valid,
    input  logic                   snap_ready,
    output snap_t                  snap,
    output logic [VALUE_WIDTH-1:0] snap_year
);

    localparam int VW = VALUE_WIDTH;
    localparam logic [VW+3:0] MAG_LIMIT_X = (VW+4)'(1) << (VW - 1);
    localparam logic [VW-1:0] MAG_LIMIT   = VW'(1) << (VW - 1);

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_NAME,
        PH_AFTER_DAY,
        PH_AFTER_COMMA,
        PH_DAY_START,
        PH_DAY_SIGN,
        PH_DAY_DIGITS,
        PH_MON_START,
        PH_MON_CHARS,
        PH_YEAR_START,
        PH_YEAR_SIGN,
        PH_YEAR_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t        phase;
        logic [23:0]   name;
        logic [1:0]    cnt;
        logic [VW-1:0] day;
        logic          day_minus;
        logic [3:0]    month;
        logic [VW-1:0] year;
        logic          year_minus;
        logic          ovf;
        logic          failed;
    } pstate_t;

    function automatic pstate_t blank_state(phase_t ph);
        pstate_t s;
        s            = '0;
        s.phase      = ph;
        return s;
    endfunction

    // Returns {overflow, new magnitude}; saturate at the limit on overflow.
    function automatic logic [VW:0] add_digit(logic [VW-1:0] mag, logic [3:0] d);
        logic [VW+3:0] sum;
        sum = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {{VW{1'b0}}, d};
        if (sum > MAG_LIMIT_X)
            return {1'b1, MAG_LIMIT};
        return {1'b0, sum[VW-1:0]};
    endfunction

    function automatic pstate_t push_name(pstate_t s, logic [7:0] c);
        pstate_t r;
        r = s;
        case (s.cnt)
            2'd0:    r.name[23:16] = c;
            2'd1:    r.name[15:8]  = c;
            2'd2:    r.name[7:0]   = c;
            default: r.name        = s.name;
        endcase
        if (s.cnt != 2'(NAME_LEN))
            r.cnt = s.cnt + 2'd1;
        return r;
    endfunction

    function automatic pstate_t day_digit(pstate_t s, logic [7:0] c);
        pstate_t     r;
        logic [VW:0] a;
        r       = s;
        a       = add_digit(s.day, c[3:0]);
        r.day   = a[VW-1:0];
        r.ovf   = s.ovf | a[VW];
        r.phase = PH_DAY_DIGITS;
        return r;
    endfunction

    function automatic pstate_t year_digit(pstate_t s, logic [7:0] c);
        pstate_t     r;
        logic [VW:0] a;
        r       = s;
        a       = add_digit(s.year, c[3:0]);
        r.year  = a[VW-1:0];
        r.ovf   = s.ovf | a[VW];
        r.phase = PH_YEAR_DIGITS;
        return r;
    endfunction

    // One byte through every phase past the day name.
    function automatic pstate_t feed(pstate_t s, logic [7:0] c);
        pstate_t r;
        logic    ws;
        logic    dig;
        logic    sgn;
        r   = s;
        ws  = is_ws(c);
        dig = is_digit(c);
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        if (!s.failed) begin
            case (s.phase)
                PH_AFTER_DAY, PH_AFTER_COMMA, PH_DAY_START:
                begin
                    if (ws) begin
                        r = s;
                    end else if ((s.phase == PH_AFTER_DAY) && (c == CH_COMMA)) begin
                        r.phase = PH_AFTER_COMMA;
                    end else if (sgn) begin
                        r.day_minus = (c == CH_MINUS);
                        r.phase     = PH_DAY_SIGN;
                    end else if (dig) begin
                        r = day_digit(s, c);
                    end else begin
                        r.failed = 1'b1;
                    end
                end
                PH_YEAR_START:
                begin
                    if (ws) begin
                        r = s;
                    end else if (sgn) begin
                        r.year_minus = (c == CH_MINUS);
                        r.phase      = PH_YEAR_SIGN;
                    end else if (dig) begin
                        r = year_digit(s, c);
                    end else begin
                        r.failed = 1'b1;
                    end
                end
                PH_DAY_SIGN:
                begin
                    if (dig)
                        r = day_digit(s, c);
                    else
                        r.failed = 1'b1;
                end
                PH_YEAR_SIGN:
                begin
                    if (dig)
                        r = year_digit(s, c);
                    else
                        r.failed = 1'b1;
                end
                PH_DAY_DIGITS:
                begin
                    if (dig) begin
                        r = day_digit(s, c);
                    end else if (ws) begin
                        r.phase = PH_MON_START;
                    end else begin
                        r       = push_name(s, c);
                        r.phase = PH_MON_CHARS;
                    end
                end
                PH_MON_START:
                begin
                    if (!ws) begin
                        r       = push_name(s, c);
                        r.phase = PH_MON_CHARS;
                    end
                end
                PH_MON_CHARS:
                begin
                    if (ws) begin
                        r.month = (s.cnt == 2'(NAME_LEN)) ? month_code(s.name) : 4'd0;
                        r.phase = PH_YEAR_START;
                    end else begin
                        r = push_name(s, c);
                    end
                end
                PH_YEAR_DIGITS:
                begin
                    if (dig)
                        r = year_digit(s, c);
                    else
                        r.phase = PH_DONE;
                end
                default:
                begin
                    r = s;
                end
            endcase
        end
        return r;
    endfunction

    logic          in_v_reg;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;

    pstate_t       main_reg;
    pstate_t       main_next;
    pstate_t       shadow_reg;
    pstate_t       shadow_next;
    pstate_t       fed;
    pstate_t       pushed;

    logic          snap_v_reg;
    snap_t         snap_reg;
    logic [VW-1:0] snap_year_reg;
    snap_t         snap_next;

    logic          is_end;
    logic          pop;
    logic          snap_free;

    assign is_end    = (in_char_reg == CH_NUL) || in_last_reg;
    assign snap_free = !snap_v_reg || snap_ready;
    // an end beat needs room in the snapshot stage; any other beat never waits
    assign pop       = in_v_reg && (!is_end || snap_free);
    assign char_in.ready = !in_v_reg || pop;

    always_comb
    begin
        pushed      = push_name(main_reg, in_char_reg);
        fed         = main_reg;
        shadow_next = shadow_reg;
        if (in_char_reg != CH_NUL) begin
            case (main_reg.phase)
                PH_LEAD:
                begin
                    if (!is_ws(in_char_reg)) begin
                        fed         = pushed;
                        fed.phase   = PH_NAME;
                        // start the no-day-name reading alongside
                        shadow_next = feed(blank_state(PH_DAY_START), in_char_reg);
                    end
                end
                PH_NAME:
                begin
                    if (pushed.cnt == 2'(NAME_LEN)) begin
                        if (is_day_name(pushed.name))
                            fed = blank_state(PH_AFTER_DAY);
                        else
                            fed = feed(shadow_reg, in_char_reg);
                    end else begin
                        fed         = pushed;
                        shadow_next = feed(shadow_reg, in_char_reg);
                    end
                end
                default:
                begin
                    fed = feed(main_reg, in_char_reg);
                end
            endcase
        end

        main_next = is_end ? blank_state(PH_LEAD) : fed;

        snap_next.base_ok    = !fed.failed && !fed.ovf && (fed.month != 4'd0) &&
                               ((fed.phase == PH_YEAR_DIGITS) || (fed.phase == PH_DONE));
        snap_next.day_minus  = fed.day_minus;
        snap_next.day_top    = fed.day[VW-1];
        snap_next.day_low    = fed.day[7:0];
        snap_next.month      = fed.month;
        snap_next.year_minus = fed.year_minus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_v_reg   <= 1'b0;
            main_reg   <= blank_state(PH_LEAD);
            snap_v_reg <= 1'b0;
        end else begin
            if (char_in.ready)
                in_v_reg <= char_in.valid;
            if (pop)
                main_reg <= main_next;
            if (snap_free)
                snap_v_reg <= pop && is_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready) begin
            in_char_reg <= char_in.char_code;
            in_last_reg <= char_in.last_char;
        end
        if (pop)
            shadow_reg <= shadow_next;
        if (pop && is_end) begin
            snap_reg      <= snap_next;
            snap_year_reg <= fed.year;
        end
    end

    assign snap_valid = snap_v_reg;
    assign snap       = snap_reg;
    assign snap_year  = snap_year_reg;

endmodule

// ----- rtl/rdp_checker.sv -----
// ----------------------------------------------------------------------------
// rdp_checker: calendar check of the date parser
// Adjusts the year, reduces day and year, checks the date against the
// Gregorian calendar and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module rdp_checker
    import rdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    input  snap_t                  snap,
    input  logic [VALUE_WIDTH-1:0] snap_year,
    rdp_out_if.source              date_out
);

    localparam int VW = VALUE_WIDTH;
    localparam int QW = 10;

    // stage A: year adjust and reduction
    logic        a_v_reg;
    logic        a_ok_reg;
    logic [15:0] a_year_reg;
    logic [7:0]  a_day_reg;
    logic [3:0]  a_month_reg;
    // stage B: year divided by 100
    logic          b_v_reg;
    logic          b_ok_reg;
    logic [15:0]   b_year_reg;
    logic [7:0]    b_day_reg;
    logic [3:0]    b_month_reg;
    logic [QW-1:0] b_quot_reg;
    // stage C: result beat
    logic        c_v_reg;
    logic        c_ok_reg;
    logic [4:0]  c_day_reg;
    logic [3:0]  c_month_reg;
    logic [15:0] c_year_reg;

    logic a_free;
    logic b_free;
    logic c_free;

    logic               ok_next;
    logic signed [VW+1:0] year_signed;
    logic [15:0]        year_next;
    logic [7:0]         day_next;
    logic [47:0]        product;
    logic [15:0]        hundreds;
    logic               rem_zero;
    logic               leap;
    logic [4:0]         limit;
    logic               final_ok;

    assign c_free     = !c_v_reg || date_out.ready;
    assign b_free     = !b_v_reg || c_free;
    assign a_free     = !a_v_reg || b_free;
    assign snap_ready = a_free;

    always_comb
    begin
        ok_next = snap.base_ok &&
                  !(!snap.day_minus && snap.day_top) &&
                  !(!snap.year_minus && snap_year[VW-1]);
        year_signed = snap.year_minus ? -$signed({2'b00, snap_year})
                                      :  $signed({2'b00, snap_year});
        year_next = year_signed[15:0];
        if (year_signed < $signed((VW+2)'(YEAR_CENTURY))) begin
            if (year_signed < $signed((VW+2)'(YEAR_PIVOT)))
                year_next = year_signed[15:0] + 16'(YEAR_MILLENNIUM);
            else
                year_next = year_signed[15:0] + 16'(YEAR_CENTURY);
        end
        day_next = snap.day_minus ? (8'd0 - snap.day_low) : snap.day_low;
    end

    assign product = {16'd0, DIV100_MAGIC} * {32'd0, a_year_reg};

    always_comb
    begin
        hundreds = ({6'd0, b_quot_reg} << 6) + ({6'd0, b_quot_reg} << 5) +
                   ({6'd0, b_quot_reg} << 2);
        rem_zero = (b_year_reg == hundreds);
        leap     = ((b_year_reg[1:0] == 2'd0) && !rem_zero) ||
                   (rem_zero && (b_quot_reg[1:0] == 2'd0));
        limit    = month_len(b_month_reg);
        if ((b_month_reg == MONTH_FEB) && leap)
            limit = 5'd29;
        final_ok = b_ok_reg && (b_year_reg != 16'd0) && (b_day_reg != 8'd0) &&
                   (b_day_reg <= {3'd0, limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            if (a_free)
                a_v_reg <= snap_valid;
            if (b_free)
                b_v_reg <= a_v_reg;
            if (c_free)
                c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free) begin
            a_ok_reg    <= ok_next;
            a_year_reg  <= year_next;
            a_day_reg   <= day_next;
            a_month_reg <= snap.month;
        end
        if (b_free) begin
            b_ok_reg    <= a_ok_reg;
            b_year_reg  <= a_year_reg;
            b_day_reg   <= a_day_reg;
            b_month_reg <= a_month_reg;
            b_quot_reg  <= product[DIV100_SHIFT+QW-1:DIV100_SHIFT];
        end
        if (c_free) begin
            c_ok_reg    <= final_ok;
            c_day_reg   <= final_ok ? b_day_reg[4:0] : 5'd0;
            c_month_reg <= final_ok ? b_month_reg : 4'd0;
            c_year_reg  <= final_ok ? b_year_reg : 16'd0;
        end
    end

    assign date_out.valid        = c_v_reg;
    assign date_out.date_valid   = c_ok_reg;
    assign date_out.day_of_month = c_day_reg;
    assign date_out.month_number = c_month_reg;
    assign date_out.year_number  = c_year_reg;

endmodule

// ----- rtl/rfc822_date_parser.sv -----
// ----------------------------------------------------------------------------
// rfc822_date_parser: streaming parser for mail-style date strings
// Reads a date string one character per beat and returns one parsed and
// calendar-checked date beat per string.
// ----------------------------------------------------------------------------
// Usage:
//   char_in carries one byte per beat (char_code) with last_char marking the
//   final byte. A NUL byte, or a byte marked last, ends the string; the NUL
//   itself is not parsed. Bytes that do not end a string give no output.
//   date_out carries one beat per string: date_valid, day_of_month,
//   month_number and year_number, all zero but for a valid date.
//   Throughput: one character beat per cycle while date_out is ready, also for
//   strings of a single byte; the parse state advances one byte per cycle.
//   Path: the ending character beat passes through the input register, the
//   snapshot, year adjust and divide by 100, then the calendar check into
//   the output register, where the date beat shows on date_out.
//   Stalls: a result beat holds on date_out until taken; the check stages
//   and input register fill behind it, and char_in.ready drops only when an
//   ending byte finds no free stage. Ordinary bytes keep flowing.
//   Reset: clears all valid flags and puts the parser at the start of a
//   string; no pass over any storage is needed.
// ----------------------------------------------------------------------------
module rfc822_date_parser
    import rdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rdp_in_if.sink    char_in,
    rdp_out_if.source date_out
);

    logic                   snap_valid;
    logic                   snap_ready;
    snap_t                  snap;
    logic [VALUE_WIDTH-1:0] snap_year;

    rdp_scanner #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .snap_year  (snap_year)
    );

    rdp_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .snap_year  (snap_year),
        .date_out   (date_out)
    );

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for rfc822_date_parser
// Streams date strings one byte per beat, predicts each parsed date with a
// byte-level model of the parser, and compares every date beat in order.
// Directed strings cover day names, signs, overflow, year pivot and leap
// rules; random strings are mostly well-formed dates with random content.
// ----------------------------------------------------------------------------
module testbench
    import rdp_pkg::*;
();

    localparam int                VALUE_BITS = 32;
    localparam longint unsigned   MAG_CAP    = 64'd1 << (VALUE_BITS - 1);
    localparam int                CLK_HALF   = 6;
    localparam int                DRAIN_CYCLES = 12;

    typedef struct packed {
        logic        date_valid;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [15:0] year_number;
    } date_t;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_NAME,
        PH_AFTER_DAY,
        PH_AFTER_COMMA,
        PH_DAY_START,
        PH_DAY_SIGN,
        PH_DAY_DIGITS,
        PH_MON_START,
        PH_MON_CHARS,
        PH_YEAR_START,
        PH_YEAR_SIGN,
        PH_YEAR_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum {END_MARK, END_NUL, END_BOTH} end_kind_t;

    logic clk;
    logic rst_n;

    rdp_in_if  char_bus ();
    rdp_out_if date_bus ();

    rfc822_date_parser #(.VALUE_WIDTH(VALUE_BITS)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .date_out (date_bus)
    );

    // Parser state as the string is scanned
    phase_t          scan_phase;
    logic [23:0]     tag_buf;
    int              tag_len;
    longint unsigned day_mag;
    logic            day_neg;
    logic [3:0]      month_sel;
    longint unsigned year_mag;
    logic            year_neg;
    logic            too_big;
    logic            bad_text;

    date_t dates_due[$];
    date_t want_date;
    int    faults;
    int    chars_sent;
    bit    steady;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(2 * CLK_HALF * 200000);
        $display("rfc822_date_parser regression: fail");
        $finish;
    end

    function automatic logic blank_byte(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic numeral(logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic [23:0] day_tag(int k);
        case (k)
            0:       return DAY_SUN;
            1:       return DAY_MON;
            2:       return DAY_TUE;
            3:       return DAY_WED;
            4:       return DAY_THU;
            5:       return DAY_FRI;
            default: return DAY_SAT;
        endcase
    endfunction

    function automatic logic [23:0] month_tag(int k);
        case (k)
            1:       return MON_JAN;
            2:       return MON_FEB;
            3:       return MON_MAR;
            4:       return MON_APR;
            5:       return MON_MAY;
            6:       return MON_JUN;
            7:       return MON_JUL;
            8:       return MON_AUG;
            9:       return MON_SEP;
            10:      return MON_OCT;
            11:      return MON_NOV;
            default: return MON_DEC;
        endcase
    endfunction

    function automatic int month_days(logic [3:0] m);
        case (m)
            4'd2:                    return 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    function automatic void clear_scan();
        scan_phase = PH_LEAD;
        tag_buf    = '0;
        tag_len    = 0;
        day_mag    = 0;
        day_neg    = 1'b0;
        month_sel  = '0;
        year_mag   = 0;
        year_neg   = 1'b0;
        too_big    = 1'b0;
        bad_text   = 1'b0;
    endfunction

    // Saturate at the signed range limit and flag the overflow
    function automatic longint unsigned grow(longint unsigned mag, logic [7:0] c);
        longint unsigned d;
        d = c - 8'd48;
        if (mag > (MAG_CAP - d) / 10) begin
            too_big = 1'b1;
            return MAG_CAP;
        end
        return mag * 10 + d;
    endfunction

    function automatic void push_tag(logic [7:0] c);
        if (tag_len < NAME_LEN) begin
            tag_buf[23 - 8 * tag_len -: 8] = c;
            tag_len++;
        end
    endfunction

    // Bytes that a phase hands on to the next phase go back to the front
    function automatic void scan_byte(logic [7:0] first);
        logic [7:0]  work[$];
        logic [7:0]  c;
        logic [23:0] held;
        logic        hit;
        logic        to_year;
        work.push_back(first);
        while (work.size() != 0)
        begin
            c = work.pop_front();
            if (bad_text)
                return;
            case (scan_phase)
                PH_LEAD:
                    if (!blank_byte(c))
                    begin
                        scan_phase = PH_NAME;
                        push_tag(c);
                    end
                PH_NAME:
                begin
                    push_tag(c);
                    if (tag_len == NAME_LEN)
                    begin
                        hit = 1'b0;
                        for (int k = 0; k < 7; k++)
                            if (tag_buf == day_tag(k))
                                hit = 1'b1;
                        held    = tag_buf;
                        tag_buf = '0;
                        tag_len = 0;
                        if (hit)
                            scan_phase = PH_AFTER_DAY;
                        else
                        begin
                            // rescan the three held bytes as the day number
                            scan_phase = PH_DAY_START;
                            work.push_front(held[7:0]);
                            work.push_front(held[15:8]);
                            work.push_front(held[23:16]);
                        end
                    end
                end
                PH_AFTER_DAY:
                    if (!blank_byte(c))
                    begin
                        if (c == CH_COMMA)
                            scan_phase = PH_AFTER_COMMA;
                        else
                        begin
                            scan_phase = PH_DAY_START;
                            work.push_front(c);
                        end
                    end
                PH_AFTER_COMMA:
                    if (!blank_byte(c))
                    begin
                        scan_phase = PH_DAY_START;
                        work.push_front(c);
                    end
                PH_DAY_START, PH_YEAR_START:
                begin
                    to_year = (scan_phase == PH_YEAR_START);
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        if (to_year)
                        begin
                            year_neg   = (c == CH_MINUS);
                            scan_phase = PH_YEAR_SIGN;
                        end
                        else
                        begin
                            day_neg    = (c == CH_MINUS);
                            scan_phase = PH_DAY_SIGN;
                        end
                    end
                    else if (numeral(c))
                    begin
                        if (to_year)
                        begin
                            scan_phase = PH_YEAR_DIGITS;
                            year_mag   = grow(year_mag, c);
                        end
                        else
                        begin
                            scan_phase = PH_DAY_DIGITS;
                            day_mag    = grow(day_mag, c);
                        end
                    end
                    else if (!blank_byte(c))
                        bad_text = 1'b1;
                end
                PH_DAY_SIGN:
                    if (!numeral(c))
                        bad_text = 1'b1;
                    else
                    begin
                        scan_phase = PH_DAY_DIGITS;
                        day_mag    = grow(day_mag, c);
                    end
                PH_YEAR_SIGN:
                    if (!numeral(c))
                        bad_text = 1'b1;
                    else
                    begin
                        scan_phase = PH_YEAR_DIGITS;
                        year_mag   = grow(year_mag, c);
                    end
                PH_DAY_DIGITS:
                    if (numeral(c))
                        day_mag = grow(day_mag, c);
                    else
                    begin
                        scan_phase = PH_MON_START;
                        work.push_front(c);
                    end
                PH_MON_START:
                    if (!blank_byte(c))
                    begin
                        scan_phase = PH_MON_CHARS;
                        push_tag(c);
                    end
                PH_MON_CHARS:
                    if (blank_byte(c))
                    begin
                        month_sel = '0;
                        if (tag_len == NAME_LEN)
                            for (int k = 1; k <= 12; k++)
                                if (tag_buf == month_tag(k))
                                    month_sel = 4'(k);
                        scan_phase = PH_YEAR_START;
                    end
                    else
                        push_tag(c);
                PH_YEAR_DIGITS:
                    if (!numeral(c))
                        scan_phase = PH_DONE;
                    else
                        year_mag = grow(year_mag, c);
                default:
                    ;
            endcase
        end
    endfunction

    // Turn the scanned fields into a checked calendar date and restart
    function automatic date_t close_string();
        date_t           r;
        logic            ok;
        longint          ys;
        longint unsigned dm;
        logic [15:0]     y;
        logic [7:0]      d;
        int              lim;
        r  = '0;
        y  = '0;
        d  = '0;
        ok = !bad_text && !too_big && month_sel >= 4'd1 && month_sel <= 4'd12 &&
             (scan_phase == PH_YEAR_DIGITS || scan_phase == PH_DONE);
        if (ok && ((!day_neg && day_mag >= MAG_CAP) || (!year_neg && year_mag >= MAG_CAP)))
            ok = 1'b0;
        if (ok)
        begin
            ys = year_neg ? -longint'(year_mag) : longint'(year_mag);
            if (ys < YEAR_CENTURY)
                ys += (ys < YEAR_PIVOT) ? YEAR_MILLENNIUM : YEAR_CENTURY;
            y   = ys[15:0];
            dm  = day_neg ? -day_mag : day_mag;
            d   = dm[7:0];
            lim = month_days(month_sel);
            if (month_sel == MONTH_FEB &&
                ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
                lim = 29;
            if (y == 0 || d == 0 || d > lim)
                ok = 1'b0;
        end
        if (ok)
        begin
            r.date_valid   = 1'b1;
            r.day_of_month = d[4:0];
            r.month_number = month_sel;
            r.year_number  = y;
        end
        clear_scan();
        return r;
    endfunction

    task automatic put_char(input logic [7:0] c, input logic last);
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        char_bus.last_char <= last;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        chars_sent++;
        if (c != CH_NUL)
            scan_byte(c);
        if (c == CH_NUL || last)
            dates_due.push_back(close_string());
    endtask

    task automatic send_text(input string s, input end_kind_t how);
        int n;
        n = s.len();
        for (int i = 0; i < n; i++)
            put_char(s[i], how == END_MARK && i == n - 1);
        if (how != END_MARK || n == 0)
            put_char(CH_NUL, how == END_BOTH);
    endtask

    function automatic end_kind_t pick_end();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return END_MARK;
        if (r < 9)
            return END_NUL;
        return END_BOTH;
    endfunction

    function automatic string blank_text();
        return $sformatf("%c", ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : 32);
    endfunction

    function automatic string big_text();
        case ($urandom_range(0, 4))
            0:       return "2147483647";
            1:       return "2147483648";
            2:       return "2147483649";
            3:       return "4294967296";
            default: return $sformatf("%0d%09d", $urandom_range(1, 999),
                                      $urandom_range(0, 999999999));
        endcase
    endfunction

    function automatic string day_text();
        case ($urandom_range(0, 11))
            0:       return "0";
            1:       return $sformatf("%0d", $urandom_range(32, 300));
            2:       return $sformatf("-%0d", $urandom_range(0, 300));
            3:       return {($urandom_range(0, 1) != 0) ? "-" : "", big_text()};
            4:       return $sformatf("+%0d", $urandom_range(1, 31));
            5:       return $sformatf("0%0d", $urandom_range(1, 31));
            6:       return $sformatf("%0d", $urandom_range(28, 31));
            default: return $sformatf("%0d", $urandom_range(1, 31));
        endcase
    endfunction

    function automatic string month_text();
        string t;
        t = $sformatf("%s", month_tag($urandom_range(1, 12)));
        case ($urandom_range(0, 11))
            0: t = t.substr(0, $urandom_range(0, 1));
            1: t = {t, "ember"};
            2: t[0] = byte'(t[0] + 8'd32);
            3: t = $sformatf("%c%c%c", $urandom_range(33, 126), $urandom_range(33, 126),
                             $urandom_range(33, 126));
            default: ;
        endcase
        return t;
    endfunction

    function automatic string year_text();
        case ($urandom_range(0, 11))
            0:       return $sformatf("%0d", $urandom_range(0, 99));
            1:       return $sformatf("-%0d", $urandom_range(0, 3000));
            2:       return $sformatf("%0d", $urandom_range(60000, 70000));
            3:       return {($urandom_range(0, 1) != 0) ? "-" : "", big_text()};
            4:       return $sformatf("+%0d", $urandom_range(1900, 2100));
            5:       return $sformatf("%0d", 100 * $urandom_range(16, 24));
            6:       return $sformatf("%0d", $urandom_range(100, 1899));
            default: return $sformatf("%0d", $urandom_range(1900, 2100));
        endcase
    endfunction

    function automatic string make_date_text();
        string s;
        string t;
        s = "";
        repeat ($urandom_range(0, 2)) s = {s, blank_text()};
        if ($urandom_range(0, 3) != 0)
        begin
            t = $sformatf("%s", day_tag($urandom_range(0, 6)));
            if ($urandom_range(0, 7) == 0)
                t[$urandom_range(0, 2)] = byte'($urandom_range(65, 122));
            s = {s, t};
            if ($urandom_range(0, 2) != 0)
                s = {s, ","};
            repeat ($urandom_range(0, 2)) s = {s, blank_text()};
        end
        s = {s, day_text()};
        if ($urandom_range(0, 9) != 0)
            s = {s, blank_text()};
        s = {s, month_text()};
        repeat ($urandom_range(1, 2)) s = {s, blank_text()};
        s = {s, year_text()};
        case ($urandom_range(0, 3))
            0: s = {s, " 08:49:37 GMT"};
            1: s = {s, $sformatf("%c%c", $urandom_range(1, 127), $urandom_range(1, 127))};
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            put_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        put_char(CH_NUL, 1'b0);
    endtask

    task automatic test_day_names();
        send_text("Sun, 06 Nov 1994 08:49:37 GMT", END_MARK);
        send_text("Thu, 01 Jan 1970 00:00:00 +0000", END_NUL);
        send_text(" \t\rSat ,\n7 Jun 2003", END_BOTH);
        send_text("Mon,31 Dec 99", END_MARK);
        send_text("12 Nov 1994", END_MARK);
        send_text("Frx 7 Oct 2000", END_MARK);
        send_text("Sunday 5 May 2005", END_MARK);
    endtask

    task automatic test_numbers();
        send_text("-255 Mar 2001", END_MARK);
        send_text("+5 Apr +2020", END_NUL);
        send_text("+15 May -100", END_MARK);
        send_text("99999999999 Jun 2000", END_MARK);
        send_text("2147483648 Jan 2000", END_MARK);
        send_text("-2147483648 Jan 2000", END_MARK);
        send_text("5 Sep 2147483647", END_MARK);
        send_text("5 Sep 2147483648", END_MARK);
    endtask

    task automatic test_calendar();
        send_text("29 Feb 2000", END_MARK);
        send_text("29 Feb 1900", END_MARK);
        send_text("1 Jan 49", END_MARK);
        send_text("1 Jan 50", END_MARK);
        send_text("1 Jul 65536", END_MARK);
        send_text("1 Aug 67436", END_MARK);
        send_text("31 Apr 2010", END_MARK);
        send_text("0 Oct 2010", END_MARK);
    endtask

    task automatic test_malformed();
        send_text("Sun, - Oct 2000", END_MARK);
        send_text("5 Ja 2000", END_MARK);
        send_text("5 January 2000", END_MARK);
        send_text("5 jan 2000", END_MARK);
        send_text("06Nov 1994", END_MARK);
        send_text("Sun, 06 Nov", END_NUL);
        send_text("Tue", END_MARK);
        send_text("", END_NUL);
        send_text("", END_BOTH);
        send_text("7", END_MARK);
        put_char(8'hFF, 1'b1);
    endtask

    task automatic test_random_dates();
        int stop_at;
        int kind;
        string s;
        stop_at = chars_sent + 570;
        while (chars_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_noise();
            else if (kind == 1)
            begin
                s = make_date_text();
                send_text(s.substr(0, $urandom_range(0, s.len() - 1)), pick_end());
            end
            else
                send_text(make_date_text(), pick_end());
        end
    endtask

    // Run the last stretch with no idling on either side
    task automatic test_steady_tail();
        int stop_at;
        steady  = 1'b1;
        stop_at = chars_sent + 150;
        while (chars_sent < stop_at)
            send_text(make_date_text(), pick_end());
    endtask

    initial
    begin
        date_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!steady && $urandom_range(0, 7) == 0)
            begin
                date_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            date_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && date_bus.valid && date_bus.ready)
        begin
            if (dates_due.size() == 0)
            begin
                $error("date beat with no string pending");
                faults++;
            end
            else
            begin
                want_date = dates_due.pop_front();
                if (date_bus.date_valid !== want_date.date_valid)
                begin
                    $error("date_valid: expected %0d, got %0d",
                           want_date.date_valid, date_bus.date_valid);
                    faults++;
                end
                if (date_bus.day_of_month !== want_date.day_of_month)
                begin
                    $error("day_of_month: expected %0d, got %0d",
                           want_date.day_of_month, date_bus.day_of_month);
                    faults++;
                end
                if (date_bus.month_number !== want_date.month_number)
                begin
                    $error("month_number: expected %0d, got %0d",
                           want_date.month_number, date_bus.month_number);
                    faults++;
                end
                if (date_bus.year_number !== want_date.year_number)
                begin
                    $error("year_number: expected %0d, got %0d",
                           want_date.year_number, date_bus.year_number);
                    faults++;
                end
            end
        end
    end

    initial
    begin
        steady     = 1'b0;
        faults     = 0;
        chars_sent = 0;
        clear_scan();
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        char_bus.last_char <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_day_names();
        test_numbers();
        test_calendar();
        test_malformed();
        test_random_dates();
        test_steady_tail();

        char_bus.valid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0 && dates_due.size() == 0)
            $display("rfc822_date_parser regression: pass");
        else
            $display("rfc822_date_parser regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rdp_pkg.sv
rtl/rdp_if.sv
rtl/rdp_scanner.sv
rtl/rdp_checker.sv
rtl/rfc822_date_parser.sv
bench/testbench.sv
